[hdl/hybrid_runge_kutta_particle_stage_core_assert.svh]
`ifndef HYBRID_RUNGE_KUTTA_PARTICLE_STAGE_CORE_ASSERT_SVH
`define HYBRID_RUNGE_KUTTA_PARTICLE_STAGE_CORE_ASSERT_SVH
// Assertion helpers for the particle stage core.
`define HRK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/hrk_pkg.sv]
`default_nettype none
package hrk_pkg;
  localparam int MAX_PARTICLES = 1024;
  localparam logic [1:0] SCH_EULER = 2'd0;
  localparam logic [1:0] SCH_RK2 = 2'd1;
  localparam logic [1:0] SCH_RK4 = 2'd2;
  localparam logic [1:0] CFG_STEP = 2'd0;
  localparam logic [1:0] CFG_THR = 2'd1;
  localparam logic [1:0] CFG_ABOVE = 2'd2;
  localparam logic [1:0] CFG_BELOW = 2'd3;
  localparam logic [32:0] SIXTH_Q32 = 33'd715827883;
  localparam logic [31:0] HALF_Q16 = 32'd32768;

  typedef struct packed {
    logic [1:0] stage;
    logic [1:0] sch;
  } hrk_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    sadd = sat32(36'(a) + 36'(b));
  endfunction

  function automatic logic signed [31:0] scale_sat(input logic signed [31:0] a,
                                                   input logic [63:0] prod_mag,
                                                   input logic [5:0] sh);
    logic [63:0] r;
    logic [63:0] lim;
    r = prod_mag >> sh;
    lim = a[31] ? 64'd2147483648 : 64'd2147483647;
    if (r > lim) begin
      r = lim;
    end
    scale_sat = a[31] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction
endpackage
`default_nettype wire

[hdl/hybrid_runge_kutta_particle_stage_core.sv]
// Channel  | Ports                                 | Handshake
// in       | in_particle_id .. in_end_of_pass      | in_valid / in_ready
// out      | out_result_id .. out_more_passes      | out_valid / out_ready
// cfg      | cfg_we, cfg_index, cfg_data           | write enable only
// Accept in IDLE (tables read at that edge); READ forms h, CALC finishes and loads
// the output register, so the result is offered in OUT, after READ and CALC.
// The next item is accepted the cycle after the result leaves.
// Synchronous active-low reset zeroes the stage counter, loads register defaults, idles.
// A stalled output holds the item; no new item enters until it leaves.
`default_nettype none
module hybrid_runge_kutta_particle_stage_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [9:0]          in_particle_id,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  input  wire logic signed [31:0]  in_vel_x,
  input  wire logic signed [31:0]  in_vel_y,
  input  wire logic signed [31:0]  in_vel_z,
  input  wire logic signed [31:0]  in_cell_corner_x,
  input  wire logic                in_end_of_pass,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [9:0]               out_result_id,
  output logic signed [31:0]       out_new_x,
  output logic signed [31:0]       out_new_y,
  output logic signed [31:0]       out_new_z,
  output logic [1:0]               out_scheme_used,
  output logic                     out_velocity_check_clear,
  output logic                     out_more_passes,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  localparam int AW = $clog2(hrk_pkg::MAX_PARTICLES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_READ = 4'b0010, ST_CALC = 4'b0100, ST_OUT = 4'b1000
  } st_t;
  st_t st_r, st_nxt;

  logic [30:0] dt_r;
  logic signed [31:0] thr_r;
  logic [1:0] above_r, below_r, stage_r;

  logic [AW-1:0] id_r;
  logic [9:0] rid_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] corner_r;
  logic eop_r;

  logic [95:0] mem_p0 [hrk_pkg::MAX_PARTICLES];
  logic [95:0] mem_k1 [hrk_pkg::MAX_PARTICLES];
  logic [95:0] mem_k2 [hrk_pkg::MAX_PARTICLES];
  logic [95:0] mem_k3 [hrk_pkg::MAX_PARTICLES];
  logic [1:0]  mem_sch [hrk_pkg::MAX_PARTICLES];
  logic [95:0] p0_q, k1_q, k2_q, k3_q;
  logic [1:0]  sch_q;

  logic [1:0] sel_sch, sch;
  logic signed [31:0] h_o [3];
  logic signed [31:0] res_o [3];
  hrk_pkg::hrk_ctl_t ctl;
  logic lane_go;

  always_comb begin
    sel_sch = (corner_r > thr_r) ? above_r : below_r;
    if (sel_sch > hrk_pkg::SCH_RK4) sel_sch = hrk_pkg::SCH_RK4;
    sch = (stage_r == 2'd0) ? sel_sch :
          ((sch_q > hrk_pkg::SCH_RK4) ? hrk_pkg::SCH_RK4 : sch_q);
    ctl.stage = stage_r;
    ctl.sch = sch;
  end
  assign lane_go = (st_r == ST_READ);

  for (genvar d = 0; d < 3; d++) begin : g_lane
    hrk_lane u_lane (
      .clk(clk), .go(lane_go), .ctl(ctl), .pos(pos_r[d]), .vel(vel_r[d]), .dt(dt_r),
      .p0(p0_q[32*d +: 32]), .k1(k1_q[32*d +: 32]), .k2(k2_q[32*d +: 32]),
      .k3(k3_q[32*d +: 32]), .h_out(h_o[d]), .res(res_o[d])
    );
  end

  hrk_pkg::hrk_ctl_t ctl_r;
  always_ff @(posedge clk) begin
    if (lane_go) ctl_r <= ctl;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p0_q <= mem_p0[in_particle_id[AW-1:0]];
      k1_q <= mem_k1[in_particle_id[AW-1:0]];
      k2_q <= mem_k2[in_particle_id[AW-1:0]];
      k3_q <= mem_k3[in_particle_id[AW-1:0]];
      sch_q <= mem_sch[in_particle_id[AW-1:0]];
    end
    if (st_r == ST_READ && stage_r == 2'd0) mem_sch[id_r] <= sel_sch;
    if (st_r == ST_CALC && ctl_r.sch != hrk_pkg::SCH_EULER) begin
      unique case (ctl_r.stage)
        2'd0: begin
          mem_p0[id_r] <= {pos_r[2], pos_r[1], pos_r[0]};
          if (ctl_r.sch == hrk_pkg::SCH_RK4) mem_k1[id_r] <= {h_o[2], h_o[1], h_o[0]};
        end
        2'd1: if (ctl_r.sch == hrk_pkg::SCH_RK4) mem_k2[id_r] <= {h_o[2], h_o[1], h_o[0]};
        2'd2: if (ctl_r.sch == hrk_pkg::SCH_RK4) mem_k3[id_r] <= {h_o[2], h_o[1], h_o[0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_r <= in_particle_id[AW-1:0];
      rid_r <= in_particle_id;
      pos_r[0] <= in_pos_x; pos_r[1] <= in_pos_y; pos_r[2] <= in_pos_z;
      vel_r[0] <= in_vel_x; vel_r[1] <= in_vel_y; vel_r[2] <= in_vel_z;
      corner_r <= in_cell_corner_x;
      eop_r <= in_end_of_pass;
    end
    if (st_r == ST_CALC) begin
      out_result_id <= rid_r;
      out_new_x <= res_o[0];
      out_new_y <= res_o[1];
      out_new_z <= res_o[2];
      out_scheme_used <= ctl_r.sch;
      out_velocity_check_clear <= (ctl_r.sch == hrk_pkg::SCH_EULER) ||
        (ctl_r.sch == hrk_pkg::SCH_RK2 && ctl_r.stage != 2'd0);
      out_more_passes <= eop_r && (stage_r != 2'd3);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_CALC;
      ST_CALC: st_nxt = ST_OUT;
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      stage_r <= 2'd0;
      dt_r <= 31'd65536;
      thr_r <= 32'sd32768;
      above_r <= hrk_pkg::SCH_RK4;
      below_r <= hrk_pkg::SCH_EULER;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CALC && eop_r) stage_r <= stage_r + 2'd1;
      if (cfg_we) begin
        unique case (cfg_index)
          hrk_pkg::CFG_STEP: dt_r <= cfg_data[30:0];
          hrk_pkg::CFG_THR: thr_r <= cfg_data;
          hrk_pkg::CFG_ABOVE: above_r <= cfg_data[1:0];
          hrk_pkg::CFG_BELOW: below_r <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[hdl/hrk_lane.sv]
`default_nettype none
// One dimension: stage 0 forms h, h/2 and the k sum, stage 1 selects the stage arithmetic and finishes.
module hrk_lane (
  input  wire logic                clk,
  input  wire logic                go,
  input  wire hrk_pkg::hrk_ctl_t   ctl,
  input  wire logic signed [31:0]  pos,
  input  wire logic signed [31:0]  vel,
  input  wire logic [30:0]         dt,
  input  wire logic signed [31:0]  p0,
  input  wire logic signed [31:0]  k1,
  input  wire logic signed [31:0]  k2,
  input  wire logic signed [31:0]  k3,
  output logic signed [31:0]       h_out,
  output logic signed [31:0]       res
);
  logic [31:0] vmag;
  logic [63:0] hprod;
  logic signed [31:0] h;
  logic [31:0] hmag;
  logic signed [31:0] half_h;
  logic signed [31:0] half_h_r;
  logic signed [31:0] sum_r;
  logic signed [31:0] sum_nxt;
  logic [31:0] smag;
  logic [64:0] sprod;
  logic signed [31:0] sixth;
  logic signed [31:0] pos_r;
  logic signed [31:0] p0_r;
  logic signed [31:0] h_r;
  hrk_pkg::hrk_ctl_t ctl_r;

  always_comb begin
    vmag = vel[31] ? 32'(-vel) : 32'(vel);
    hprod = 64'(vmag) * 64'(dt);
    h = hrk_pkg::scale_sat(vel, hprod, 6'd16);
    hmag = h[31] ? 32'(-h) : 32'(h);
    half_h = hrk_pkg::scale_sat(h, 64'(hmag) * 64'(hrk_pkg::HALF_Q16), 6'd16);
    sum_nxt = hrk_pkg::sadd(hrk_pkg::sadd(hrk_pkg::sadd(k1, hrk_pkg::sadd(k2, k2)),
                                          hrk_pkg::sadd(k3, k3)), h);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sum_r <= sum_nxt;
      pos_r <= pos;
      p0_r <= p0;
      h_r <= h;
      half_h_r <= half_h;
      ctl_r <= ctl;
    end
  end

  always_comb begin
    smag = sum_r[31] ? 32'(-sum_r) : 32'(sum_r);
    sprod = 65'(smag) * 65'(hrk_pkg::SIXTH_Q32);
    sixth = hrk_pkg::scale_sat(sum_r, sprod[63:0], 6'd32);
    h_out = h_r;
    res = pos_r;
    case (ctl_r.sch)
      hrk_pkg::SCH_EULER: begin
        if (ctl_r.stage == 2'd0) res = hrk_pkg::sadd(pos_r, h_r);
      end
      hrk_pkg::SCH_RK2: begin
        if (ctl_r.stage == 2'd0) res = hrk_pkg::sadd(pos_r, half_h_r);
        else if (ctl_r.stage == 2'd1) res = hrk_pkg::sadd(p0_r, h_r);
      end
      default: begin
        case (ctl_r.stage)
          2'd0: res = hrk_pkg::sadd(pos_r, half_h_r);
          2'd1: res = hrk_pkg::sadd(p0_r, half_h_r);
          2'd2: res = hrk_pkg::sadd(p0_r, h_r);
          default: res = hrk_pkg::sadd(p0_r, sixth);
        endcase
      end
    endcase
  end
endmodule
`default_nettype wire

[hdl/hrk_checker.sv]
`default_nettype none
`include "hybrid_runge_kutta_particle_stage_core_assert.svh"
module hrk_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_scheme_used,
  input wire logic out_velocity_check_clear
);
  `HRK_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
  `HRK_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `HRK_ASSERT_IMPL(a_sch, clk, rst_n, out_valid, out_scheme_used <= hrk_pkg::SCH_RK4)
  `HRK_ASSERT_IMPL(a_rk4, clk, rst_n, out_valid && out_scheme_used == hrk_pkg::SCH_RK4,
                   !out_velocity_check_clear)
  `HRK_ASSERT_NEXT(a_acc, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule
bind hybrid_runge_kutta_particle_stage_core hrk_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_scheme_used(out_scheme_used),
  .out_velocity_check_clear(out_velocity_check_clear)
);
`default_nettype wire
